// ===== design/rrlf_pkg.sv =====
package rrlf_pkg;

  // Field and register widths
  localparam int ChanW    = 8;
  localparam int IdxW     = 6;
  localparam int CntW     = 7;
  localparam int EnW      = 3;
  localparam int SegW     = 5;
  localparam int SegEndW  = 6;
  localparam int DivCntW  = 4;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 8;
  localparam int InDataW  = 8;
  localparam int OutDataW = 32;

  localparam int MaxLedsDefault = 64;
  localparam int MinLeds        = 3;

  localparam logic [ChanW-1:0] ColorFull = 8'hFF;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgLedCount   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgBrightDiv  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgChanEnable = 2'd2;

  // Channel enable bit positions
  localparam int EnRed   = 2;
  localparam int EnGreen = 1;
  localparam int EnBlue  = 0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_UP_START,
    ST_UP_WAIT,
    ST_CH_WAIT,
    ST_EMIT
  } rrlf_state_t;

  // floor(x/3) for x < 192 via multiply by 171 and shift by 9
  function automatic logic [SegEndW-1:0] div3(input logic [7:0] x);
    logic [15:0] prod;
    prod = 16'(x) * 16'd171;
    return prod[14:9];
  endfunction

endpackage

// ===== design/rotating_rainbow_led_frame_unit.sv =====
// Rotating rainbow frame generator. Each beat on the input with frame_tick set
// renders one frame of led_count pixels (one output beat per pixel, tlast on the
// final one) and then advances the rotation by one; a beat with frame_tick clear
// is taken and ignored. A frame first reduces the stored offset modulo led_count,
// then makes two passes per pixel through bit-serial dividers: one for the ramp
// 255*c/s and one, on three lanes at once, for the brightness divisor. The next
// pixel is computed while the previous one waits in the output register. Write
// configuration only between frames.
module rotating_rainbow_led_frame_unit
  import rrlf_pkg::*;
#(
  parameter int MAX_LEDS = MaxLedsDefault
) (
  input  logic                clk,
  input  logic                rst_n,
  // input beat: [0] frame_tick
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [InDataW-1:0]  in_tdata,
  // output beat: [5:0] pixel_index, [13:6] red, [21:14] green, [29:22] blue
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OutDataW-1:0] out_tdata,
  output logic                out_tlast,
  // configuration write
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_LEDS);
  localparam logic [CntW-1:0] MinCnt = CntW'(MinLeds);

  rrlf_state_t state_r, state_nxt;

  logic [CntW-1:0]    led_count_r;
  logic [ChanW-1:0]   bdiv_r;
  logic [EnW-1:0]     chen_r;
  logic [IdxW-1:0]    offset_r, offset_nxt;
  logic [IdxW-1:0]    om_r, om_nxt;
  logic [IdxW-1:0]    idx_r, idx_nxt;
  logic [IdxW-1:0]    i_r, i_nxt;
  logic [SegW-1:0]    c_r, c_nxt;
  logic [SegW-1:0]    s_r, s_nxt;
  logic [SegEndW-1:0] cut2_r, cut2_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [OutDataW-1:0] out_data_r, out_data_nxt;
  logic               out_last_r, out_last_nxt;

  logic [2:0]         dv_start;
  logic [2:0]         dv_busy;
  logic [ChanW-1:0]   dv_q [3];
  logic [2*ChanW-1:0] dv_dividend [3];
  logic [ChanW-1:0]   dv_divisor [3];

  logic               in_acc;
  logic               seg1, seg2;
  logic [ChanW-1:0]   up, red, green, blue;
  logic               is_last;
  logic [CntW-1:0]    i_inc, om_inc, idx_inc;
  logic [CntW-1:0]    cfg_cnt;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // Configuration registers with clamping
  assign cfg_cnt = cfg_data[CntW-1:0];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      led_count_r <= MaxCnt;
      bdiv_r      <= ChanW'(1);
      chen_r      <= '1;
    end else if (cfg_valid) begin
      case (cfg_index)
        CfgLedCount: begin
          if (cfg_cnt < MinCnt) begin
            led_count_r <= MinCnt;
          end else if (cfg_cnt > MaxCnt) begin
            led_count_r <= MaxCnt;
          end else begin
            led_count_r <= cfg_cnt;
          end
        end
        CfgBrightDiv: begin
          bdiv_r <= (cfg_data == '0) ? ChanW'(1) : cfg_data;
        end
        CfgChanEnable: begin
          chen_r <= cfg_data[EnW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Color of the current pixel from the ramp quotient
  assign up   = dv_q[0];
  assign seg1 = (i_r < {1'b0, s_r});
  assign seg2 = (i_r < cut2_r);
  always_comb begin
    if (seg1) begin
      red   = up;
      green = '0;
      blue  = ColorFull - up;
    end else if (seg2) begin
      red   = ColorFull - up;
      green = up;
      blue  = '0;
    end else begin
      red   = '0;
      green = ColorFull - up;
      blue  = up;
    end
    if (!chen_r[EnRed])   red   = '0;
    if (!chen_r[EnGreen]) green = '0;
    if (!chen_r[EnBlue])  blue  = '0;
  end

  assign i_inc   = {1'b0, i_r} + 1'b1;
  assign om_inc  = {1'b0, om_r} + 1'b1;
  assign idx_inc = {1'b0, idx_r} + 1'b1;
  assign is_last = (i_inc == led_count_r);

  // Frame sequencer
  always_comb begin
    state_nxt     = state_r;
    offset_nxt    = offset_r;
    om_nxt        = om_r;
    idx_nxt       = idx_r;
    i_nxt         = i_r;
    c_nxt         = c_r;
    s_nxt         = s_r;
    cut2_nxt      = cut2_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    dv_start      = '0;
    for (int k = 0; k < 3; k++) begin
      dv_dividend[k] = {{ChanW{1'b0}}, ColorFull};
      dv_divisor[k]  = bdiv_r;
    end

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc && in_tdata[0]) begin
          s_nxt     = SegW'(div3({1'b0, led_count_r}));
          cut2_nxt  = div3({led_count_r, 1'b0});
          om_nxt    = offset_r;
          state_nxt = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if ({1'b0, om_r} >= led_count_r) begin
          om_nxt = IdxW'({1'b0, om_r} - led_count_r);
        end else begin
          idx_nxt   = om_r;
          i_nxt     = '0;
          c_nxt     = '0;
          state_nxt = ST_UP_START;
        end
      end
      ST_UP_START: begin
        // 255*c as (c << 8) - c
        dv_dividend[0] = {3'b000, c_r, {ChanW{1'b0}}} - {{(2*ChanW-SegW){1'b0}}, c_r};
        dv_divisor[0]  = {3'b000, s_r};
        dv_start[0]    = 1'b1;
        state_nxt      = ST_UP_WAIT;
      end
      ST_UP_WAIT: begin
        if (!dv_busy[0]) begin
          dv_dividend[0] = {{ChanW{1'b0}}, red};
          dv_dividend[1] = {{ChanW{1'b0}}, green};
          dv_dividend[2] = {{ChanW{1'b0}}, blue};
          dv_start       = '1;
          state_nxt      = ST_CH_WAIT;
        end
      end
      ST_CH_WAIT: begin
        if (dv_busy == '0) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {2'b00, dv_q[2], dv_q[1], dv_q[0], idx_r};
          out_last_nxt  = is_last;
          if (is_last) begin
            offset_nxt = (om_inc == led_count_r) ? '0 : om_inc[IdxW-1:0];
            state_nxt  = ST_IDLE;
          end else begin
            i_nxt   = i_inc[IdxW-1:0];
            idx_nxt = (idx_inc == led_count_r) ? '0 : idx_inc[IdxW-1:0];
            if ((i_inc == {2'b00, s_r}) || (i_inc == {1'b0, cut2_r})) begin
              c_nxt = '0;
            end else begin
              c_nxt = c_r + 1'b1;
            end
            state_nxt = ST_UP_START;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      offset_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      offset_r    <= offset_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    om_r       <= om_nxt;
    idx_r      <= idx_nxt;
    i_r        <= i_nxt;
    c_r        <= c_nxt;
    s_r        <= s_nxt;
    cut2_r     <= cut2_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  // Divider lanes: lane 0 computes the ramp, then all three scale the channels
  for (genvar k = 0; k < 3; k++) begin : g_lane
    rrlf_sdiv u_div (
      .clk      (clk),
      .rst_n    (rst_n),
      .start    (dv_start[k]),
      .dividend (dv_dividend[k]),
      .divisor  (dv_divisor[k]),
      .busy     (dv_busy[k]),
      .quotient (dv_q[k])
    );
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

// ===== design/rrlf_sdiv.sv =====
// Bit-serial restoring divider: one quotient bit per cycle.
// The dividend's upper byte must be below the divisor, so the quotient fits 8 bits.
module rrlf_sdiv
  import rrlf_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [2*ChanW-1:0] dividend,
  input  logic [ChanW-1:0]   divisor,
  output logic               busy,
  output logic [ChanW-1:0]   quotient
);

  logic [ChanW-1:0]   rem_r, rem_nxt;
  logic [ChanW-1:0]   q_r, q_nxt;
  logic [ChanW-1:0]   dvs_r, dvs_nxt;
  logic [DivCntW-1:0] cnt_r, cnt_nxt;
  logic [ChanW:0]     trial;
  logic               fits;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    rem_nxt = rem_r;
    q_nxt   = q_r;
    dvs_nxt = dvs_r;
    cnt_nxt = cnt_r;
    trial   = {rem_r, q_r[ChanW-1]};
    fits    = (trial >= {1'b0, dvs_r});
    if (start) begin
      rem_nxt = dividend[2*ChanW-1:ChanW];
      q_nxt   = dividend[ChanW-1:0];
      dvs_nxt = divisor;
      cnt_nxt = DivCntW'(ChanW);
    end else if (cnt_r != '0) begin
      rem_nxt = fits ? ChanW'(trial - {1'b0, dvs_r}) : trial[ChanW-1:0];
      q_nxt   = {q_r[ChanW-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy     = (cnt_r != '0);
  assign quotient = q_r;

endmodule

// ===== sim/testbench.sv =====
module testbench;
  import rrlf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // index 3 is not decoded by the block; writes to it must be dropped
  localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;
  localparam int unsigned SettleCycles = 1400;
  localparam int unsigned CycleLimit   = 3000000;
  localparam int unsigned Full         = ColorFull;

  typedef struct {
    logic [IdxW-1:0]  idx;
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic             last;
  } pixel_t;

  // Rainbow frame predictor plus in-order pixel checker
  class pixel_scoreboard;
    int unsigned  led_count;
    int unsigned  bright_div;
    logic [EnW-1:0] chan_en;
    int unsigned  rot_offset;
    pixel_t       pending_q[$];
    int           errors;
    int           frames;
    int           pixels;
    int           idle_ticks;
    int           reg_writes;

    function new();
      led_count  = MaxLedsDefault;
      bright_div = 1;
      chan_en    = 3'b111;
      rot_offset = 0;
      errors     = 0;
      frames     = 0;
      pixels     = 0;
      idle_ticks = 0;
      reg_writes = 0;
    endfunction

    function void apply_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      int unsigned v;
      reg_writes++;
      case (idx)
        CfgLedCount: begin
          v = data & 8'h7F;
          if (v < MinLeds) v = MinLeds;
          else if (v > MaxLedsDefault) v = MaxLedsDefault;
          led_count = v;
        end
        CfgBrightDiv: begin
          bright_div = (data == 0) ? 1 : data;
        end
        CfgChanEnable: begin
          chan_en = data[EnW-1:0];
        end
        default: ;
      endcase
    endfunction

    // One accepted tick: queue every pixel of the frame, then rotate
    function void note_tick(logic tick);
      int unsigned n, s, cut1, cut2, c, up, r, g, b;
      pixel_t px;
      if (!tick) begin
        idle_ticks++;
        return;
      end
      n    = led_count;
      s    = n / 3;
      cut1 = s;
      cut2 = (2 * n) / 3;
      for (int unsigned i = 0; i < n; i++) begin
        if (i < cut1) c = i;
        else if (i < cut2) c = i - cut1;
        else c = i - cut2;
        up = (Full * c) / s;
        if (up > Full) up = Full;
        if (i < cut1) begin
          r = up;        g = 0;         b = Full - up;
        end else if (i < cut2) begin
          r = Full - up; g = up;        b = 0;
        end else begin
          r = 0;         g = Full - up; b = up;
        end
        if (!chan_en[EnRed])   r = 0;
        if (!chan_en[EnGreen]) g = 0;
        if (!chan_en[EnBlue])  b = 0;
        px.idx   = IdxW'((i + rot_offset) % n);
        px.red   = ChanW'(r / bright_div);
        px.green = ChanW'(g / bright_div);
        px.blue  = ChanW'(b / bright_div);
        px.last  = (i == n - 1);
        pending_q.push_back(px);
      end
      rot_offset = (rot_offset + 1) % n;
      frames++;
    endfunction

    function void compare(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_pixel(logic [OutDataW-1:0] data, logic last);
      pixel_t want;
      if (pending_q.size() == 0) begin
        $error("pixel beat with nothing pending: pixel_index %0d", data[IdxW-1:0]);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      pixels++;
      compare("pixel_index", want.idx,   data[IdxW-1:0]);
      compare("red",         want.red,   data[IdxW +: ChanW]);
      compare("green",       want.green, data[IdxW+ChanW +: ChanW]);
      compare("blue",        want.blue,  data[IdxW+2*ChanW +: ChanW]);
      compare("last_pixel",  want.last,  last);
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata;
  logic                out_tvalid;
  logic                out_tready;
  logic [OutDataW-1:0] out_tdata;
  logic                out_tlast;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  pixel_scoreboard sb = new();
  bit              calm;
  int unsigned     cycle_count;
  int              sent;

  rotating_rainbow_led_frame_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Beat monitors, sampled at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_pixel(out_tdata, out_tlast);
      if (in_tvalid && in_tready) sb.note_tick(in_tdata[0]);
      if (cfg_valid && cfg_ready) sb.apply_reg(cfg_index, cfg_data);
    end
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Sink back-pressure
  initial begin
    int stall_left;
    out_tready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0 && !calm) begin
        out_tready = 1'b0;
        stall_left--;
      end else begin
        out_tready = 1'b1;
        stall_left = ($urandom_range(0, 99) < 30) ? pick_gap() : 0;
      end
    end
  end

  task automatic send_tick(input logic tick);
    int gap;
    gap = calm ? 0 : pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_tvalid = 1'b0;
    end
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata  = {{(InDataW-1){1'b0}}, tick};
    do @(posedge clk); while (!in_tready);
  endtask

  // Stop sending, wait for every queued pixel, then let the block go quiet
  task automatic drain_pixels(input int unsigned extra);
    @(negedge clk);
    in_tvalid = 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [CfgDataW-1:0] pick_count();
    case ($urandom_range(0, 9))
      0:       return 8'd3;
      1:       return 8'd64;
      2, 3:    return CfgDataW'($urandom);
      default: return CfgDataW'($urandom_range(3, 20));
    endcase
  endfunction

  function automatic logic [CfgDataW-1:0] pick_div();
    case ($urandom_range(0, 9))
      0:       return 8'd1;
      1:       return 8'd255;
      2:       return 8'd0;
      3:       return CfgDataW'($urandom);
      default: return CfgDataW'($urandom_range(1, 8));
    endcase
  endfunction

  initial begin
    int   phase_len;
    logic tick;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    calm      = 1'b1;
    sent      = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset settings, full strip; an idle tick in between must be ignored
    send_tick(1'b1);
    send_tick(1'b0);
    repeat (4) send_tick(1'b1);
    calm = 1'b0;

    // Short strip clamp with an offset left over from the long strip
    drain_pixels(SettleCycles);
    write_reg(CfgLedCount, 8'd1);
    repeat (2) send_tick(1'b1);

    // Long strip clamp, zero divisor, dead register, all channels off
    drain_pixels(SettleCycles);
    write_reg(CfgLedCount, 8'hFF);
    write_reg(CfgBrightDiv, 8'd0);
    write_reg(CfgUnused, 8'hA5);
    write_reg(CfgChanEnable, 8'd0);
    repeat (2) send_tick(1'b1);

    // Largest divisor, four pixels
    drain_pixels(SettleCycles);
    write_reg(CfgLedCount, 8'd4);
    write_reg(CfgBrightDiv, 8'd255);
    write_reg(CfgChanEnable, 8'd7);
    repeat (3) send_tick(1'b1);

    // Green masked, divide by two, five pixels
    drain_pixels(SettleCycles);
    write_reg(CfgLedCount, 8'd5);
    write_reg(CfgBrightDiv, 8'd2);
    write_reg(CfgChanEnable, 8'd5);
    send_tick(1'b1);
    send_tick(1'b0);
    repeat (2) send_tick(1'b1);

    // Random phases: fresh settings, then a burst of mostly live ticks
    while (sent < 140) begin
      drain_pixels(SettleCycles);
      calm = ($urandom_range(0, 3) == 0);
      write_reg(CfgLedCount, pick_count());
      write_reg(CfgBrightDiv, pick_div());
      write_reg(CfgChanEnable, CfgDataW'($urandom));
      if ($urandom_range(0, 3) == 0) write_reg(CfgUnused, CfgDataW'($urandom));
      phase_len = $urandom_range(10, 25);
      repeat (phase_len) begin
        tick = ($urandom_range(0, 9) != 0);
        send_tick(tick);
        if (tick) sent++;
        if ($urandom_range(0, 19) == 0) drain_pixels(0);
      end
    end

    drain_pixels(SettleCycles);
    $display("Rendered %0d frames (%0d pixel beats checked), %0d idle ticks, %0d reg writes",
             sb.frames, sb.pixels, sb.idle_ticks, sb.reg_writes);
    $display("Strip lengths 3..64, divisors 1..255, all channel masks, stale offsets");
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/rrlf_pkg.sv
design/rrlf_sdiv.sv
design/rotating_rainbow_led_frame_unit.sv
sim/testbench.sv
